>>> sv/drt_pkg.sv
// Package for the diagnostic response timer: event, phase and cause codes,
// register indexes, reset values and the state and result structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package drt_pkg;

    localparam int TimerWidth   = 16;
    localparam int SidWidth     = 8;
    localparam int FuncWidth    = 3;
    localparam int PhaseWidth   = 2;
    localparam int CauseWidth   = 2;
    localparam int CfgIdxWidth  = 8;

    // Event codes.
    localparam logic [FuncWidth-1:0] FuncStart    = 3'd0;
    localparam logic [FuncWidth-1:0] FuncStop     = 3'd1;
    localparam logic [FuncWidth-1:0] FuncAck      = 3'd2;
    localparam logic [FuncWidth-1:0] FuncNack     = 3'd3;
    localparam logic [FuncWidth-1:0] FuncResponse = 3'd4;
    localparam logic [FuncWidth-1:0] FuncPending  = 3'd5;
    localparam logic [FuncWidth-1:0] FuncTick     = 3'd6;

    // Phase codes.
    localparam logic [PhaseWidth-1:0] PhaseIdle = 2'd0;
    localparam logic [PhaseWidth-1:0] PhaseAck  = 2'd1;
    localparam logic [PhaseWidth-1:0] PhaseResp = 2'd2;

    // Finish causes.
    localparam logic [CauseWidth-1:0] CauseSuppressed = 2'd0;
    localparam logic [CauseWidth-1:0] CauseNack       = 2'd1;
    localparam logic [CauseWidth-1:0] CauseResponse   = 2'd2;
    localparam logic [CauseWidth-1:0] CauseTimeout    = 2'd3;

    // Register indexes.
    localparam logic [CfgIdxWidth-1:0] RegAckTimeout      = 8'd0;
    localparam logic [CfgIdxWidth-1:0] RegResponseTimeout = 8'd1;
    localparam logic [CfgIdxWidth-1:0] RegPendingTimeout  = 8'd2;
    localparam logic [CfgIdxWidth-1:0] RegNodeAddress     = 8'd3;

    // Register reset values.
    localparam logic [TimerWidth-1:0] AckTimeoutReset      = 16'd2000;
    localparam logic [TimerWidth-1:0] ResponseTimeoutReset = 16'd50;
    localparam logic [TimerWidth-1:0] PendingTimeoutReset  = 16'd2000;
    localparam logic [TimerWidth-1:0] NodeAddressReset     = 16'd0;

    typedef struct packed {
        logic [PhaseWidth-1:0] phase;
        logic [TimerWidth-1:0] remaining;
        logic [SidWidth-1:0]   sid;
        logic                  suppress;
    } t_state;

    typedef struct packed {
        logic [TimerWidth-1:0] ack_timeout;
        logic [TimerWidth-1:0] response_timeout;
        logic [TimerWidth-1:0] pending_timeout;
        logic [TimerWidth-1:0] node_address;
    } t_cfg;

    typedef struct packed {
        logic                  finish;
        logic [TimerWidth-1:0] finish_address;
        logic [CauseWidth-1:0] finish_cause;
        logic [PhaseWidth-1:0] phase_now;
    } t_result;

endpackage

`default_nettype wire

>>> sv/drt_ifs.sv
// Valid/ready channel interfaces of the diagnostic response timer:
// event requests, result requests and register writes.
// Depends on drt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface drt_req_if;
    logic                           valid;
    logic                           ready;
    logic [drt_pkg::FuncWidth-1:0]  func;
    logic [drt_pkg::SidWidth-1:0]   service_id;
    logic                           suppress_response;

    modport source (output valid, output func, output service_id,
                    output suppress_response, input ready);
    modport sink   (input valid, input func, input service_id,
                    input suppress_response, output ready);
endinterface

interface drt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           finish;
    logic [drt_pkg::TimerWidth-1:0] finish_address;
    logic [drt_pkg::CauseWidth-1:0] finish_cause;
    logic [drt_pkg::PhaseWidth-1:0] phase_now;

    modport source (output valid, output finish, output finish_address,
                    output finish_cause, output phase_now, input ready);
    modport sink   (input valid, input finish, input finish_address,
                    input finish_cause, input phase_now, output ready);
endinterface

interface drt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [drt_pkg::CfgIdxWidth-1:0] index;
    logic [drt_pkg::TimerWidth-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/drt_core.sv
// Next-state and result logic of the diagnostic response timer for one event.
// Depends on drt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drt_core (
    input  wire logic [drt_pkg::FuncWidth-1:0] i_func,
    input  wire logic [drt_pkg::SidWidth-1:0]  i_service_id,
    input  wire logic                          i_suppress_response,
    input  wire drt_pkg::t_state               i_state,
    input  wire drt_pkg::t_cfg                 i_cfg,
    output drt_pkg::t_state                    o_state,
    output drt_pkg::t_result                   o_result
);

    logic                            match;
    logic                            done;
    logic [drt_pkg::CauseWidth-1:0]  cause;

    assign match = (i_service_id == i_state.sid);

    always_comb begin
        o_state = i_state;
        done    = 1'b0;
        cause   = drt_pkg::CauseSuppressed;
        unique case (i_func)
            drt_pkg::FuncStart: begin
                o_state.sid       = i_service_id;
                o_state.suppress  = i_suppress_response;
                o_state.phase     = drt_pkg::PhaseAck;
                o_state.remaining = i_cfg.ack_timeout;
            end
            drt_pkg::FuncStop: begin
                if (match) begin
                    o_state.phase     = drt_pkg::PhaseIdle;
                    o_state.remaining = '0;
                end
            end
            drt_pkg::FuncAck: begin
                if (i_state.phase == drt_pkg::PhaseAck) begin
                    if (!i_state.suppress) begin
                        o_state.phase     = drt_pkg::PhaseResp;
                        o_state.remaining = i_cfg.response_timeout;
                    end else begin
                        o_state.phase     = drt_pkg::PhaseIdle;
                        o_state.remaining = '0;
                        done              = 1'b1;
                        cause             = drt_pkg::CauseSuppressed;
                    end
                end
            end
            drt_pkg::FuncNack: begin
                if (i_state.phase == drt_pkg::PhaseAck) begin
                    o_state.phase     = drt_pkg::PhaseIdle;
                    o_state.remaining = '0;
                    done              = 1'b1;
                    cause             = drt_pkg::CauseNack;
                end
            end
            drt_pkg::FuncResponse: begin
                if (match && i_state.phase == drt_pkg::PhaseResp) begin
                    o_state.phase     = drt_pkg::PhaseIdle;
                    o_state.remaining = '0;
                    done              = 1'b1;
                    cause             = drt_pkg::CauseResponse;
                end
            end
            drt_pkg::FuncPending: begin
                if (match && i_state.phase == drt_pkg::PhaseResp) begin
                    o_state.remaining = i_cfg.pending_timeout;
                end
            end
            drt_pkg::FuncTick: begin
                if (i_state.phase != drt_pkg::PhaseIdle) begin
                    // A timer loaded with zero expires on its first tick, like one.
                    if (i_state.remaining <= drt_pkg::TimerWidth'(1)) begin
                        o_state.phase     = drt_pkg::PhaseIdle;
                        o_state.remaining = '0;
                        done              = 1'b1;
                        cause             = drt_pkg::CauseTimeout;
                    end else begin
                        o_state.remaining = i_state.remaining - drt_pkg::TimerWidth'(1);
                    end
                end
            end
            default: begin
                // Unknown event code: no change, no finish.
            end
        endcase

        o_result.finish         = done;
        o_result.finish_address = done ? i_cfg.node_address : '0;
        o_result.finish_cause   = done ? cause : drt_pkg::CauseSuppressed;
        o_result.phase_now      = o_state.phase;
    end

endmodule

`default_nettype wire

>>> sv/diagnostic_response_timeout_fsm.sv
// Top level of the diagnostic response timer: register file, request state and
// result register. Depends on drt_pkg, the channel interfaces and drt_core.
`timescale 1ns / 1ps
`default_nettype none

// The block follows one diagnostic request through its timing phases and
// answers every event request with exactly one result request. An event is
// accepted whenever the result register is empty or its result is being taken
// in the same cycle, so one event per clock is sustained while the consumer
// keeps up, and each result is registered in the cycle after its event.
// The whole update of the request state (a compare of the service id, a load
// of a timeout or a decrement of the 16-bit tick counter) is combinational,
// and the state register is written at the same edge as the result register,
// so the next event already sees it. The three timeouts and the node address
// are written through the configuration channel, which is always ready;
// writes to indexes beyond the register list are accepted and dropped.
// Registers should only be written while no event result is outstanding.

module diagnostic_response_timeout_fsm (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    drt_req_if.sink     i_req,
    drt_rsp_if.source   o_rsp,
    drt_cfg_if.sink     i_cfg
);

    drt_pkg::t_cfg    r_cfg;
    drt_pkg::t_state  r_state;
    drt_pkg::t_state  n_state;
    drt_pkg::t_result r_result;
    drt_pkg::t_result n_result;
    logic             r_valid;
    logic             accept;

    // Register writes are taken in every cycle.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack_timeout      <= drt_pkg::AckTimeoutReset;
            r_cfg.response_timeout <= drt_pkg::ResponseTimeoutReset;
            r_cfg.pending_timeout  <= drt_pkg::PendingTimeoutReset;
            r_cfg.node_address     <= drt_pkg::NodeAddressReset;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                drt_pkg::RegAckTimeout:      r_cfg.ack_timeout      <= i_cfg.data;
                drt_pkg::RegResponseTimeout: r_cfg.response_timeout <= i_cfg.data;
                drt_pkg::RegPendingTimeout:  r_cfg.pending_timeout  <= i_cfg.data;
                drt_pkg::RegNodeAddress:     r_cfg.node_address     <= i_cfg.data;
                default: begin
                    // Writes outside the register list have no effect.
                end
            endcase
        end
    end

    // The result register frees itself in the cycle its result is taken, so
    // the event side keeps streaming while the consumer keeps up.
    assign i_req.ready = !r_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    drt_core u_core (
        .i_func              (i_req.func),
        .i_service_id        (i_req.service_id),
        .i_suppress_response (i_req.suppress_response),
        .i_state             (r_state),
        .i_cfg               (r_cfg),
        .o_state             (n_state),
        .o_result            (n_result)
    );

    // Request state advances only on accepted events.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase     <= drt_pkg::PhaseIdle;
            r_state.remaining <= '0;
            r_state.sid       <= '0;
            r_state.suppress  <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    // The payload needs no reset; it is only looked at while valid is high.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_rsp.valid          = r_valid;
    assign o_rsp.finish         = r_result.finish;
    assign o_rsp.finish_address = r_result.finish_address;
    assign o_rsp.finish_cause   = r_result.finish_cause;
    assign o_rsp.phase_now      = r_result.phase_now;

endmodule

`default_nettype wire
